[rtl/ple_pkg.sv]
`default_nettype none

package ple_pkg;

  // Field widths of the transaction ports
  localparam int MODE_W   = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Default sizing of the store
  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_DELETE = 2'd1;
  localparam mode_t MODE_READ   = 2'd2;

  // Result status codes
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_BAD_POS = 2'd1;
  localparam status_t STATUS_FULL    = 2'd2;

endpackage

`default_nettype wire

[rtl/ple_ram.sv]
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/positional_list_engine_unit.sv]
`default_nettype none

// Ordered list store with insert/delete at a 1-based position and full read-out.
// Input channel (in_valid/in_stall): mode, position, value. A transaction is taken
// only while the sequencer is idle; in_stall is high for the whole time one
// operation runs.
// Output channel (out_valid/out_stall): status, element_count, element_value,
// has_element, last_of_run. Results sit in an output register, so the next input
// transaction can be taken while the last result still waits on out_stall.
// While in_stall is high the sequencer runs one operation step by step:
//   insert: entries from the last down to the position move back one at a time,
//   each read and then written, then the value is written in its place
//   delete: entries after the position move forward one at a time
//   read-out: each stored entry is read, then loaded into the output register
// Errors and empty read-out go straight to the result. The steps follow from the
// entry memory (one write port, registered read) and the shared index adder that
// steps the sequencer. An output stall holds read-out at the pending entry.
// Reset empties the list (count to zero) and drops any pending result; entry
// memory is not cleared, entries beyond the count are never read.
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [POS_W-1:0]   position,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [STATUS_W-1:0]     status,
  output logic [COUNT_W-1:0]      element_count,
  output logic [VALUE_W-1:0]      element_value,
  output logic                    has_element,
  output logic                    last_of_run
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_WR   = 3'd2;
  localparam logic [2:0] S_DEL_RD   = 3'd3;
  localparam logic [2:0] S_DEL_WR   = 3'd4;
  localparam logic [2:0] S_OUT_RD   = 3'd5;
  localparam logic [2:0] S_OUT_DATA = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0]            state, state_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [AW-1:0]         idx, idx_next;
  logic [AW-1:0]         tgt, tgt_next;
  logic [DATA_WIDTH-1:0] val_r, val_next;
  status_t               resp_status, resp_status_next;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  step_dec;
  logic [CW-1:0]         step_sum;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic                  ins_bad;
  logic                  del_bad;
  logic                  is_full;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  out_has;
  logic                  out_last;
  status_t               out_status;
  logic [DATA_WIDTH-1:0] out_data;

  logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
  logic [DATA_WIDTH+VALUE_W-1:0] rdata_ext;

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared index unit: step up for delete and read-out, down for insert
  assign step_dec = (state == S_INS_RD) || (state == S_INS_WR);
  assign step_sum = step_dec ? (CW'(idx) - CW'(1)) : (CW'(idx) + CW'(1));

  // Position checks against the current count
  assign pos_x   = PW'(position);
  assign cnt_x   = PW'(cnt);
  assign ins_bad = (position == '0) || (pos_x > (cnt_x + PW'(1)));
  assign del_bad = (position == '0) || (pos_x > cnt_x);
  assign is_full = (cnt == CW'(CAPACITY));

  // Fit the input value into the storage width and the result value to the port
  assign value_ext = {{DATA_WIDTH{1'b0}}, value};
  assign rdata_ext = {{VALUE_W{1'b0}}, out_data};

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Sequencer
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    idx_next         = idx;
    tgt_next         = tgt;
    val_next         = val_r;
    resp_status_next = resp_status;
    ram_we           = 1'b0;
    ram_waddr        = idx;
    ram_wdata        = ram_rdata;
    ram_raddr        = idx;
    out_load         = 1'b0;
    out_has          = 1'b0;
    out_last         = 1'b1;
    out_status       = resp_status;
    out_data         = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_INSERT: begin
              if (ins_bad) begin
                resp_status_next = STATUS_BAD_POS;
                state_next       = S_RESP;
              end else if (is_full) begin
                resp_status_next = STATUS_FULL;
                state_next       = S_RESP;
              end else begin
                idx_next   = AW'(cnt);
                tgt_next   = AW'(position - POS_W'(1));
                val_next   = value_ext[DATA_WIDTH-1:0];
                state_next = S_INS_RD;
              end
            end
            MODE_DELETE: begin
              if (del_bad) begin
                resp_status_next = STATUS_BAD_POS;
                state_next       = S_RESP;
              end else begin
                idx_next   = AW'(position - POS_W'(1));
                state_next = S_DEL_RD;
              end
            end
            MODE_READ: begin
              idx_next = '0;
              if (cnt == '0) begin
                resp_status_next = STATUS_OK;
                state_next       = S_RESP;
              end else begin
                state_next = S_OUT_RD;
              end
            end
            default: begin
              resp_status_next = STATUS_BAD_POS;
              state_next       = S_RESP;
            end
          endcase
        end
      end
      // Insert: move entries back one at a time, then drop the value in place
      S_INS_RD: begin
        ram_raddr = step_sum[AW-1:0];
        if (idx == tgt) begin
          ram_we           = 1'b1;
          ram_wdata        = val_r;
          cnt_next         = cnt + CW'(1);
          resp_status_next = STATUS_OK;
          state_next       = S_RESP;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we     = 1'b1;
        idx_next   = step_sum[AW-1:0];
        state_next = S_INS_RD;
      end
      // Delete: pull later entries forward to close the gap
      S_DEL_RD: begin
        ram_raddr = step_sum[AW-1:0];
        if (step_sum < cnt) begin
          state_next = S_DEL_WR;
        end else begin
          cnt_next         = cnt - CW'(1);
          resp_status_next = STATUS_OK;
          state_next       = S_RESP;
        end
      end
      S_DEL_WR: begin
        ram_we     = 1'b1;
        idx_next   = step_sum[AW-1:0];
        state_next = S_DEL_RD;
      end
      // Read-out: fetch one entry, hold it until the output register frees
      S_OUT_RD: begin
        state_next = S_OUT_DATA;
      end
      S_OUT_DATA: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_has    = 1'b1;
          out_last   = (step_sum == cnt);
          out_status = STATUS_OK;
          out_data   = ram_rdata;
          if (step_sum == cnt) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = step_sum[AW-1:0];
            state_next = S_OUT_RD;
          end
        end
      end
      // Single result for insert, delete, errors and empty read-out
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    tgt         <= tgt_next;
    val_r       <= val_next;
    resp_status <= resp_status_next;
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= out_status;
      element_count <= COUNT_W'(cnt);
      element_value <= rdata_ext[VALUE_W-1:0];
      has_element   <= out_has;
      last_of_run   <= out_last;
    end
  end

`ifndef SYNTH
  // Count never runs past the store size
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("list count above capacity");

  // Count moves only on the cycle that commits an insert or delete
  a_cnt_commit: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (cnt != $past(cnt)) |-> (state == S_RESP))
    else $error("list count changed outside a commit");

  // Read-out never writes the entry memory
  a_readout_no_write: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT_RD) || (state == S_OUT_DATA)) |-> !ram_we)
    else $error("entry write during read-out");

  // A result carrying an entry always reports success
  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_element |-> (status == STATUS_OK))
    else $error("entry result with error status");
`endif

endmodule

`default_nettype wire
